// ===== rtl/core/ladder_lowpass_filter_core_defines.svh =====
// Assertion macros shared by the filter core.
`ifndef LADDER_LOWPASS_FILTER_CORE_DEFINES_SVH
`define LADDER_LOWPASS_FILTER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define LLF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define LLF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define LLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/llf_pkg.sv =====
package llf_pkg;

  localparam int CHANNELS    = 2;
  localparam int OVERSAMPLE  = 2;
  localparam int SAMPLE_BITS = 24;

  localparam int STATE_W  = 32;
  localparam int STAGES   = 4;
  localparam int SLOTS    = 6;
  localparam int SLOT_LAST_PREV = 4;
  localparam int SLOT_AVG = 5;
  localparam int DEPTH    = SLOTS * CHANNELS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PASS_W   = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam int STAGE_W  = $clog2(STAGES);

  localparam int TUNE_W      = 17;
  localparam int FB_W        = 19;
  localparam int WET_W       = 17;
  localparam int CFG_DATA_W  = 19;
  localparam int CFG_INDEX_W = 2;

  localparam int GAIN_ONE = 65536;
  localparam int FB_MAX   = 327680;

  localparam int PROD_W = 52;
  localparam int RND_W  = PROD_W - 16;
  localparam int WIDE_W = 40;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TUNE     = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_WET      = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FB_MUL,
    S_FB_SUB,
    S_ST_MUL,
    S_ST_ACC,
    S_AVG,
    S_WR_LAST,
    S_MIX_DRY,
    S_MIX_WET,
    S_MIX_SUM,
    S_DONE
  } state_t;

  // Saturates a wide signed value to the 32-bit state format.
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sd2147483647);
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      return hi[STATE_W-1:0];
    end else if (v < lo) begin
      return lo[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

  // Rounds a Q16 product to nearest, ties toward positive infinity.
  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + PROD_W'(32768);
    return t[PROD_W-1:16];
  endfunction

endpackage

// ===== rtl/core/llf_ram.sv =====
module llf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ladder_lowpass_filter_core.sv =====
// Four-stage ladder low-pass filter with dry/wet mix, two stereo channels.
// Input channel: sample and channel move in one beat when sample_valid is high
// and sample_stall is low. The core takes one sample at a time; sample_stall is
// high from acceptance until the result has been placed in the output register.
// Output channel: one mixed_sample beat per input beat, held in an output
// register while result_stall is high. A new sample is taken while an earlier
// result still waits there.
// Processing: the state memory serves one read and one write a cycle. Each pass
// runs the feedback (S_FB_MUL, S_FB_SUB), a multiply and an accumulate step per
// ladder stage (S_ST_MUL, S_ST_ACC), then the average and the last-stage write
// (S_AVG, S_WR_LAST); after OVERSAMPLE passes the mix (S_MIX_DRY, S_MIX_WET,
// S_MIX_SUM) and the output load (S_DONE) follow.
// Configuration: cfg_valid/cfg_ready write cfg_data into the register chosen
// by cfg_index (0 tune, 1 feedback, 2 wet); cfg_ready is always high.
// Reset (rst, synchronous) restores the default gains, empties the output
// register and marks all stored filter state as zero at once.
`include "ladder_lowpass_filter_core_defines.svh"

module ladder_lowpass_filter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [llf_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   channel,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [llf_pkg::SAMPLE_BITS-1:0] mixed_sample,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [llf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [llf_pkg::CFG_DATA_W-1:0]         cfg_data
);

  import llf_pkg::*;

  localparam logic signed [RND_W-1:0] SMP_HI = RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SMP_LO = -SMP_HI - RND_W'(1);

  state_t state;
  state_t state_next;

  logic [TUNE_W-1:0] tune_gain;
  logic [FB_W-1:0]   feedback_gain;
  logic [WET_W-1:0]  wet_gain;

  logic [PASS_W-1:0]               pass;
  logic [STAGE_W-1:0]              stage;
  logic [ADDR_W-1:0]               base;
  logic signed [SAMPLE_BITS-1:0]   smp;
  logic signed [STATE_W-1:0]       cur;
  logic signed [STATE_W-1:0]       dk;
  logic signed [STATE_W-1:0]       avg;
  logic signed [PROD_W-1:0]        prod;
  logic signed [PROD_W-1:0]        acc;
  logic signed [SAMPLE_BITS-1:0]   res;

  logic [DEPTH-1:0]   entry_valid;
  logic               rd_valid;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [STATE_W-1:0] wr_data;
  logic [STATE_W-1:0] ram_q;

  logic [ADDR_W-1:0]         in_base;
  logic [TUNE_W-1:0]         tg_eff;
  logic [FB_W-1:0]           fb_eff;
  logic [WET_W-1:0]          wg_eff;
  logic [WET_W-1:0]          dry_gain;
  logic signed [TUNE_W:0]    tg_s;
  logic signed [FB_W:0]      fb_s;
  logic signed [WET_W:0]     wg_s;
  logic signed [WET_W:0]     dry_s;
  logic signed [STATE_W-1:0] rdata;
  logic signed [STATE_W:0]   diff;
  logic signed [STATE_W-1:0] x_val;
  logic signed [STATE_W-1:0] stage_new;
  logic signed [STATE_W-1:0] avg_new;
  logic signed [RND_W-1:0]   mix_rnd;
  logic                      load_out;

  llf_ram #(
    .WIDTH(STATE_W),
    .DEPTH(DEPTH)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_IDLE);
  assign load_out     = (state == S_DONE) && (!result_valid || !result_stall);

  assign in_base = (32'(channel) >= CHANNELS) ? ADDR_W'((CHANNELS - 1) * SLOTS)
                                              : ADDR_W'(32'(channel) * SLOTS);

  assign tg_eff   = (32'(tune_gain) > GAIN_ONE) ? TUNE_W'(GAIN_ONE) : tune_gain;
  assign fb_eff   = (32'(feedback_gain) > FB_MAX) ? FB_W'(FB_MAX) : feedback_gain;
  assign wg_eff   = (32'(wet_gain) > GAIN_ONE) ? WET_W'(GAIN_ONE) : wet_gain;
  assign dry_gain = WET_W'(GAIN_ONE) - wg_eff;
  assign tg_s     = $signed({1'b0, tg_eff});
  assign fb_s     = $signed({1'b0, fb_eff});
  assign wg_s     = $signed({1'b0, wg_eff});
  assign dry_s    = $signed({1'b0, dry_gain});

  // Entries never written since reset read as zero.
  assign rdata = rd_valid ? $signed(ram_q) : '0;

  assign diff      = (STATE_W + 1)'(cur) - (STATE_W + 1)'(rdata);
  assign x_val     = sat32(WIDE_W'(smp) - WIDE_W'(rnd16(prod)));
  assign stage_new = sat32(WIDE_W'(dk) + WIDE_W'(rnd16(prod)));
  assign avg_new   = sat32((WIDE_W'(cur) + WIDE_W'(rdata) + WIDE_W'(1)) >>> 1);
  assign mix_rnd   = rnd16(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = base;
    wr_en      = 1'b0;
    wr_addr    = base;
    wr_data    = cur;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          rd_en      = 1'b1;
          rd_addr    = in_base + ADDR_W'(SLOT_AVG);
          state_next = S_FB_MUL;
        end
      end
      S_FB_MUL: begin
        rd_en      = 1'b1;
        rd_addr    = base;
        state_next = S_FB_SUB;
      end
      S_FB_SUB: begin
        state_next = S_ST_MUL;
      end
      S_ST_MUL: begin
        state_next = S_ST_ACC;
      end
      S_ST_ACC: begin
        wr_en   = 1'b1;
        wr_addr = base + ADDR_W'(stage);
        wr_data = stage_new;
        rd_en   = 1'b1;
        if (32'(stage) == STAGES - 1) begin
          rd_addr    = base + ADDR_W'(SLOT_LAST_PREV);
          state_next = S_AVG;
        end else begin
          rd_addr    = base + ADDR_W'(stage) + ADDR_W'(1);
          state_next = S_ST_MUL;
        end
      end
      S_AVG: begin
        wr_en      = 1'b1;
        wr_addr    = base + ADDR_W'(SLOT_AVG);
        wr_data    = avg_new;
        state_next = S_WR_LAST;
      end
      S_WR_LAST: begin
        wr_en   = 1'b1;
        wr_addr = base + ADDR_W'(SLOT_LAST_PREV);
        wr_data = cur;
        if (32'(pass) == OVERSAMPLE - 1) begin
          state_next = S_MIX_DRY;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = base + ADDR_W'(SLOT_AVG);
          state_next = S_FB_MUL;
        end
      end
      S_MIX_DRY: begin
        state_next = S_MIX_WET;
      end
      S_MIX_WET: begin
        state_next = S_MIX_SUM;
      end
      S_MIX_SUM: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          smp  <= sample;
          base <= in_base;
          pass <= '0;
        end
      end
      S_FB_MUL: begin
        prod <= fb_s * rdata;
      end
      S_FB_SUB: begin
        cur   <= x_val;
        stage <= '0;
      end
      S_ST_MUL: begin
        prod <= tg_s * diff;
        dk   <= rdata;
      end
      S_ST_ACC: begin
        cur   <= stage_new;
        stage <= stage + STAGE_W'(1);
      end
      S_AVG: begin
        avg <= avg_new;
      end
      S_WR_LAST: begin
        pass <= pass + PASS_W'(1);
      end
      S_MIX_DRY: begin
        acc <= smp * dry_s;
      end
      S_MIX_WET: begin
        acc <= acc + avg * wg_s;
      end
      S_MIX_SUM: begin
        if (mix_rnd > SMP_HI) begin
          res <= SMP_HI[SAMPLE_BITS-1:0];
        end else if (mix_rnd < SMP_LO) begin
          res <= SMP_LO[SAMPLE_BITS-1:0];
        end else begin
          res <= mix_rnd[SAMPLE_BITS-1:0];
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= entry_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mixed_sample <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tune_gain     <= TUNE_W'(47278);
      feedback_gain <= '0;
      wet_gain      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TUNE:     tune_gain     <= cfg_data[TUNE_W-1:0];
        CFG_FEEDBACK: feedback_gain <= cfg_data[FB_W-1:0];
        CFG_WET:      wet_gain      <= cfg_data[WET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  `LLF_ASSERT_IMPLIES(a_wr_in_block, clk, rst, wr_en,
    (wr_addr >= base) && (32'(wr_addr) < 32'(base) + SLOTS),
    "state write outside the current channel block")
  `LLF_ASSERT_IMPLIES(a_no_rw_collision, clk, rst, rd_en && wr_en, rd_addr != wr_addr,
    "state read and write hit the same entry in one cycle")
  `LLF_ASSERT_IMPLIES(a_pass_bound, clk, rst, state != S_IDLE, 32'(pass) < OVERSAMPLE,
    "pass counter beyond the oversampling factor")
  `LLF_ASSERT_NEXT(a_result_loaded, clk, rst, load_out,
    result_valid && (mixed_sample == $past(res)),
    "finished result not presented on the output register")

endmodule

// ===== tb/ladder_lowpass_filter_compare.sv =====
module ladder_lowpass_filter_compare (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  input  logic                                   sample_stall,
  input  logic signed [llf_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   channel,
  input  logic                                   result_valid,
  input  logic                                   result_stall,
  input  logic signed [llf_pkg::SAMPLE_BITS-1:0] mixed_sample,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [llf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [llf_pkg::CFG_DATA_W-1:0]         cfg_data,
  output int                                     mismatch_count,
  output int                                     mixes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import llf_pkg::*;

  logic signed [STATE_W-1:0] ladder_state [CHANNELS][SLOTS];
  logic signed [STATE_W-1:0] stage_input [CHANNELS][STAGES-1];
  logic [TUNE_W-1:0] tune_reg;
  logic [FB_W-1:0] feedback_reg;
  logic [WET_W-1:0] wet_reg;
  logic signed [SAMPLE_BITS-1:0] expected_mix_q [$];
  logic signed [SAMPLE_BITS-1:0] oldest_mix;

  initial mismatch_count = 0;
  initial mixes_pending = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Floor of (v + 2^15) / 2^16, ties go toward plus infinity.
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [STATE_W-1:0] clamp_state(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[STATE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
    input logic signed [SAMPLE_BITS-1:0] smp_in,
    input logic                          ch
  );
    longint smp;
    longint tg;
    longint fb;
    longint wg;
    longint mix;
    longint hi;
    int chan;
    logic signed [STATE_W-1:0] x;
    logic signed [STATE_W-1:0] prev;
    logic signed [STATE_W-1:0] ref_val;
    smp = smp_in;
    tg = (tune_reg > GAIN_ONE) ? GAIN_ONE : tune_reg;
    fb = (feedback_reg > FB_MAX) ? FB_MAX : feedback_reg;
    wg = (wet_reg > GAIN_ONE) ? GAIN_ONE : wet_reg;
    chan = (int'(ch) >= CHANNELS) ? CHANNELS - 1 : int'(ch);
    for (int p = 0; p < OVERSAMPLE; p++) begin
      x = clamp_state(smp - round_q16(fb * longint'(ladder_state[chan][SLOT_AVG])));
      prev = clamp_state(longint'(ladder_state[chan][0]) +
                         round_q16(tg * (longint'(x) - longint'(stage_input[chan][0]))));
      ladder_state[chan][0] = prev;
      for (int k = 1; k < STAGES; k++) begin
        stage_input[chan][k-1] = prev;
        ref_val = (k < STAGES - 1) ? stage_input[chan][k] : ladder_state[chan][k];
        prev = clamp_state(longint'(ladder_state[chan][k]) +
                           round_q16(tg * (longint'(prev) - longint'(ref_val))));
        ladder_state[chan][k] = prev;
      end
      ladder_state[chan][SLOT_AVG] =
        clamp_state((longint'(prev) + longint'(ladder_state[chan][SLOT_LAST_PREV]) + 1) >>> 1);
      ladder_state[chan][SLOT_LAST_PREV] = prev;
    end
    mix = round_q16(smp * (GAIN_ONE - wg) + longint'(ladder_state[chan][SLOT_AVG]) * wg);
    hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    if (mix > hi) begin
      mix = hi;
    end
    if (mix < -hi - 1) begin
      mix = -hi - 1;
    end
    return mix[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int s = 0; s < SLOTS; s++) begin
          ladder_state[c][s] = '0;
        end
        for (int s = 0; s < STAGES - 1; s++) begin
          stage_input[c][s] = '0;
        end
      end
      tune_reg = TUNE_W'(47278);
      feedback_reg = '0;
      wet_reg = '0;
      expected_mix_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TUNE:     tune_reg = cfg_data[TUNE_W-1:0];
          CFG_FEEDBACK: feedback_reg = cfg_data[FB_W-1:0];
          CFG_WET:      wet_reg = cfg_data[WET_W-1:0];
          default:      ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_mix_q.size() == 0) begin
          report_mismatch($sformatf("mixed_sample %0d with no beat outstanding",
                                    mixed_sample));
        end else begin
          oldest_mix = expected_mix_q.pop_front();
          if (mixed_sample !== oldest_mix) begin
            report_mismatch($sformatf("mixed_sample got %0d, want %0d",
                                      mixed_sample, oldest_mix));
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        expected_mix_q.push_back(filter_sample(sample, channel));
      end
    end
    mixes_pending <= expected_mix_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import llf_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic channel = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] mixed_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_t cfg_index = CFG_TUNE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count;
  int mixes_pending;

  ladder_lowpass_filter_core DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .channel      (channel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mixed_sample (mixed_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ladder_lowpass_filter_compare compare (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .channel        (channel),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .mixed_sample   (mixed_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .mixes_pending  (mixes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_BITS'(int'($urandom_range(511)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain(input int unsigned full_scale);
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DATA_W'(full_scale);
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(full_scale));
    endcase
  endfunction

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_gains(input logic [CFG_DATA_W-1:0] tune_v,
                            input logic [CFG_DATA_W-1:0] fb_v,
                            input logic [CFG_DATA_W-1:0] wet_v);
    write_reg(CFG_TUNE, tune_v);
    write_reg(CFG_FEEDBACK, fb_v);
    write_reg(CFG_WET, wet_v);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic ch);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    channel <= ch;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (mixes_pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b1);
    send_sample(SAMPLE_BITS'(-1), 1'b1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_BITS'(1), 1'b0);

    wait_drained();
    load_gains(CFG_DATA_W'(GAIN_ONE), CFG_DATA_W'(FB_MAX), CFG_DATA_W'(GAIN_ONE));
    for (int i = 0; i < 8; i++) begin
      send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i[1]);
    end

    // Gains beyond their full scale must behave as full scale.
    wait_drained();
    load_gains({CFG_DATA_W{1'b1}} >> 2, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}} >> 2);
    for (int i = 0; i < 6; i++) begin
      send_sample((i % 3 == 0) ? SAMPLE_MAX : pick_sample(), i[0]);
    end

    wait_drained();
    load_gains('0, '0, CFG_DATA_W'(GAIN_ONE / 2));
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_BITS'(123), 1'b0);
    send_sample(SAMPLE_BITS'(-5), 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      load_gains(pick_gain(GAIN_ONE), pick_gain(FB_MAX), pick_gain(GAIN_ONE));
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          idle_pct = 26;
          stall_pct = 26;
        end
      endcase
      repeat (60) begin
        if ($urandom_range(49) == 0) begin
          wait_drained();
        end
        send_sample(pick_sample(), 1'($urandom_range(1)));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && mixes_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
